### sv/sha256md_pkg.sv
// ----------------------------------------------------------------------------
// sha256md_pkg
// Types, constants and round functions shared by the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } item_t;

    typedef struct packed {
        logic [63:0] digest_chunk;
        logic [1:0]  chunk_index;
        logic        chunk_last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic       write_byte;
        logic       pad;
        logic       len;
        logic       round;
        logic [5:0] round_idx;
        logic       finalize;
        logic       restart;
        logic [1:0] chunk_idx;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pos_last;   // next byte fills the block
        logic rem_ge56;   // length field does not fit, two pad blocks
    } dp_status_t;

    localparam logic [1:0] LAST_CHUNK = 2'd3;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    // Byte placed in its big-endian lane of a word.
    function automatic logic [31:0] lane_put(input logic [7:0] b, input logic [1:0] lane);
        logic [31:0] w;
        case (lane)
            2'd0:    w = {b, 24'd0};
            2'd1:    w = {8'd0, b, 16'd0};
            2'd2:    w = {16'd0, b, 8'd0};
            2'd3:    w = {24'd0, b};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

### sv/sha256md_ctrl.sv
// ----------------------------------------------------------------------------
// sha256md_ctrl
// Sequencer: byte intake, compression rounds, padding and digest readout.
// ----------------------------------------------------------------------------
module sha256md_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  sha256md_pkg::item_t     item,
    output logic                    result_valid,
    input  logic                    result_stall,
    input  sha256md_pkg::dp_status_t status,
    output sha256md_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [1:0] chunk_reg, chunk_next;
    logic       end_pend_reg, end_pend_next;
    logic       after_pad_reg, after_pad_next;
    logic       need_len_reg, need_len_next;
    logic       accept;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign accept       = item_valid && !item_stall;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        chunk_next     = chunk_reg;
        end_pend_next  = end_pend_reg;
        after_pad_next = after_pad_reg;
        need_len_next  = need_len_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.chunk_idx  = chunk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.write_byte = item.byte_present;
                    if (item.byte_present && status.pos_last)
                    begin
                        end_pend_next = item.message_end;
                        state_next    = S_ROUND;
                    end
                    else if (item.message_end)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.pad        = 1'b1;
                after_pad_next = 1'b1;
                need_len_next  = status.rem_ge56;
                state_next     = S_ROUND;
            end
            S_LEN:
            begin
                cmd.len    = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg == sha256md_pkg::LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = S_FINAL;
                end
                else
                begin
                    round_next = round_reg + 6'd1;
                end
            end
            S_FINAL:
            begin
                cmd.finalize = 1'b1;
                if (!after_pad_reg)
                begin
                    end_pend_next = 1'b0;
                    state_next    = end_pend_reg ? S_PAD : S_IDLE;
                end
                else if (need_len_reg)
                begin
                    need_len_next = 1'b0;
                    state_next    = S_LEN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    if (chunk_reg == sha256md_pkg::LAST_CHUNK)
                    begin
                        cmd.restart    = 1'b1;
                        after_pad_next = 1'b0;
                        chunk_next     = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        chunk_next = chunk_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            chunk_reg     <= '0;
            end_pend_reg  <= 1'b0;
            after_pad_reg <= 1'b0;
            need_len_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            chunk_reg     <= chunk_next;
            end_pend_reg  <= end_pend_next;
            after_pad_reg <= after_pad_next;
            need_len_reg  <= need_len_next;
        end
    end

endmodule

### sv/sha256md_dp.sv
// ----------------------------------------------------------------------------
// sha256md_dp
// Block buffer / schedule window, round registers, hash words, byte count.
// ----------------------------------------------------------------------------
module sha256md_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256md_pkg::ctrl_cmd_t  cmd,
    input  logic [7:0]               data_byte,
    output sha256md_pkg::dp_status_t status,
    output logic [63:0]              digest_chunk
);

    logic [31:0] blk_reg   [16];
    logic [31:0] blk_next  [16];
    logic [31:0] hash_reg  [8];
    logic [31:0] hash_next [8];
    logic [31:0] work_reg  [8];
    logic [31:0] work_next [8];
    logic [31:0] rin       [8];
    logic [60:0] count_reg, count_next;

    logic [5:0]  pos;
    logic [3:0]  word;
    logic [1:0]  lane;
    logic [63:0] bits;
    logic [31:0] t1, t2, w_new;

    assign pos  = count_reg[5:0];
    assign word = pos[5:2];
    assign lane = pos[1:0];
    assign bits = {count_reg, 3'd0};

    assign status.pos_last = (pos == sha256md_pkg::LAST_POS);
    assign status.rem_ge56 = (pos >= sha256md_pkg::LEN_POS);

    assign digest_chunk = {hash_reg[{cmd.chunk_idx, 1'b0}], hash_reg[{cmd.chunk_idx, 1'b1}]};

    // round 0 starts from the hash words
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rin[i] = (cmd.round_idx == '0) ? hash_reg[i] : work_reg[i];
        end
    end

    assign t1 = rin[7] + sha256md_pkg::big_sig1(rin[4])
              + sha256md_pkg::choose(rin[4], rin[5], rin[6])
              + sha256md_pkg::ROUND_K[cmd.round_idx] + blk_reg[0];
    assign t2 = sha256md_pkg::big_sig0(rin[0]) + sha256md_pkg::majority(rin[0], rin[1], rin[2]);
    assign w_new = blk_reg[0] + sha256md_pkg::small_sig0(blk_reg[1]) + blk_reg[9]
                 + sha256md_pkg::small_sig1(blk_reg[14]);

    always_comb
    begin
        blk_next   = blk_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        count_next = count_reg;

        if (cmd.write_byte)
        begin
            // first lane of a word clears the stale bits
            if (lane == 2'd0)
                blk_next[word] = sha256md_pkg::lane_put(data_byte, lane);
            else
                blk_next[word] = blk_reg[word] | sha256md_pkg::lane_put(data_byte, lane);
            count_next = count_reg + 61'd1;
        end

        if (cmd.pad)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) == word)
                begin
                    if (lane == 2'd0)
                        blk_next[i] = sha256md_pkg::lane_put(sha256md_pkg::PAD_BYTE, lane);
                    else
                        blk_next[i] = blk_reg[i]
                                    | sha256md_pkg::lane_put(sha256md_pkg::PAD_BYTE, lane);
                end
                else if (4'(i) > word)
                begin
                    blk_next[i] = '0;
                end
            end
            if (!status.rem_ge56)
            begin
                blk_next[14] = bits[63:32];
                blk_next[15] = bits[31:0];
            end
        end

        if (cmd.len)
        begin
            for (int i = 0; i < 14; i++)
            begin
                blk_next[i] = '0;
            end
            blk_next[14] = bits[63:32];
            blk_next[15] = bits[31:0];
        end

        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_next[i] = blk_reg[i + 1];
            end
            blk_next[15] = w_new;
            work_next[7] = rin[6];
            work_next[6] = rin[5];
            work_next[5] = rin[4];
            work_next[4] = rin[3] + t1;
            work_next[3] = rin[2];
            work_next[2] = rin[1];
            work_next[1] = rin[0];
            work_next[0] = t1 + t2;
        end

        if (cmd.finalize)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end

        if (cmd.restart)
        begin
            hash_next  = sha256md_pkg::HASH_INIT;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= sha256md_pkg::HASH_INIT;
            work_reg  <= '{default: '0};
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            work_reg  <= work_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

### sv/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 of a byte stream, digest delivered as four 64-bit chunks.
// ----------------------------------------------------------------------------
// Bytes arrive one per beat on the item channel and are taken one per cycle
// while the block is idle. Each 64th byte starts a compression of 64 rounds,
// one round per cycle in a single shared round unit, then a fold of the round
// registers into the hash words; no byte is taken until that fold is done. A
// beat with message_end closes the message (a byte on the same beat is taken
// first; a bare end beat may close an empty message). Closing takes a padding
// step and one compression, or two compressions with a length step between
// them when at most eight bytes are left in the last block. Then the digest
// appears as four result beats, chunk 0 holding hash words 0 and 1; each is
// held until taken. item_stall is high whenever the block is not idle, from
// the padding or compression until the last chunk is taken; a beat with
// neither a byte nor an end is taken and does nothing. The bit length wraps
// modulo 2^64.
// ----------------------------------------------------------------------------
module sha256_message_digest (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sha256md_pkg::item_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sha256md_pkg::result_t result
);

    sha256md_pkg::ctrl_cmd_t  cmd;
    sha256md_pkg::dp_status_t status;
    logic [63:0]              digest_chunk;

    sha256md_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sha256md_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (item.data_byte),
        .status       (status),
        .digest_chunk (digest_chunk)
    );

    // chunk payload comes straight from registers, stable while stalled
    assign result.digest_chunk = digest_chunk;
    assign result.chunk_index  = cmd.chunk_idx;
    assign result.chunk_last   = (cmd.chunk_idx == sha256md_pkg::LAST_CHUNK);

endmodule

### sv/sha256md_checker.sv
// ----------------------------------------------------------------------------
// sha256md_checker
// Port-level checks on the digest block, bound to the top level.
// ----------------------------------------------------------------------------
module sha256md_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input sha256md_pkg::result_t result
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // no byte intake while the digest is being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item taken during digest readout");

    // last flag marks chunk three only
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.chunk_last == (result.chunk_index == 2'd3)))
        else $error("chunk_last mismatch");

    // chunks follow each other in order without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.chunk_last |=>
            result_valid && (result.chunk_index == 2'($past(result.chunk_index) + 2'd1)))
        else $error("chunk sequence broken");

endmodule

bind sha256_message_digest sha256md_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
